// ===== rtl/core/tsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbm_pkg
// Shared types, codes and helpers for the track segment best-match block.
// ----------------------------------------------------------------------------
package tsbm_pkg;

    localparam int MAX_REFS_DEF = 1024;

    // Field widths
    localparam int POS_W   = 23;
    localparam int SLOPE_W = 16;
    localparam int ID_W    = 24;
    localparam int PLATE_W = 7;
    localparam int SEG_W   = 6;
    localparam int MODE_W  = 2;
    localparam int DIST_W  = 20;
    localparam int OUT_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Internal arithmetic widths
    localparam int OFF_W  = 27;          // rounded Q3 offsets
    localparam int NORM_W = 2 * OFF_W;   // squared distance
    localparam int ROOT_W = 27;          // floor square root

    localparam logic [ROOT_W-1:0] SCORE_LIMIT = ROOT_W'(80000);

    // Input modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEGMENTS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PLATE_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PLATE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_PLATE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_PLATE_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_OFFSET_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_OFFSET_Y   = 3'd6;

    // Register reset values
    localparam logic [SEG_W-1:0]   RST_MIN_SEGMENTS   = 6'd3;
    localparam logic [PLATE_W-1:0] RST_REF_PLATE_LOW  = 7'd26;
    localparam logic [PLATE_W-1:0] RST_REF_PLATE_HIGH = 7'd31;
    localparam logic [PLATE_W-1:0] RST_QRY_PLATE_LOW  = 7'd31;
    localparam logic [PLATE_W-1:0] RST_QRY_PLATE_LIM  = 7'd40;

    typedef struct packed {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
        logic signed [SLOPE_W-1:0] sx;
        logic signed [SLOPE_W-1:0] sy;
        logic [ID_W-1:0]           id;
        logic [PLATE_W-1:0]        fp;
        logic [PLATE_W-1:0]        lp;
    } ref_entry_t;

    // Per-pair data that rides alongside the square-root pipelines
    typedef struct packed {
        logic signed [OFF_W-1:0] fx;
        logic signed [OFF_W-1:0] fy;
        logic signed [OFF_W-1:0] mx;
        logic signed [OFF_W-1:0] my;
        logic [ID_W-1:0]         id;
        logic [PLATE_W-1:0]      fp;
        logic [PLATE_W-1:0]      gap;
    } side_t;

    typedef struct packed {
        logic load;    // store the input item as a reference
        logic clear;   // empty the reference store
        logic start;   // latch the query and reset the winner
        logic issue;   // read the next reference into the pipeline
    } tsbm_cmd_t;

    typedef struct packed {
        logic load_ok;
        logic query_ok;
        logic refs_empty;
        logic issue_last;
        logic pipe_busy;
    } tsbm_status_t;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] v);
        if (|v[ROOT_W-1:DIST_W]) begin
            return {DIST_W{1'b1}};
        end
        return v[DIST_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_off(input logic signed [OFF_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[OFF_W-1:OUT_W-1];
        all_zero = ~|v[OFF_W-1:OUT_W-1];
        if (all_one || all_zero) begin
            return v[OUT_W-1:0];
        end
        return v[OFF_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/core/tsbm_isqrt.sv =====
// ----------------------------------------------------------------------------
// tsbm_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tsbm_isqrt #(
    parameter int NORM_W = 54,
    parameter int ROOT_W = 27
) (
    input  logic              aclk,
    input  logic [NORM_W-1:0] radicand,
    output logic [ROOT_W-1:0] root
);
    localparam int TW = NORM_W + 2;

    logic [NORM_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [NORM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [TW-1:0]     trial;
        logic [NORM_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb begin
            trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
            if (TW'(rem_in) >= trial) begin
                rem_next  = rem_in - trial[NORM_W-1:0];
                root_next = root_in | (ROOT_W'(1) << B);
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== rtl/core/tsbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsbm_ctrl
// Sequencer: takes requests, runs the reference scan, presents the result.
// ----------------------------------------------------------------------------
module tsbm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tsbm_pkg::MODE_W-1:0]   s_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  tsbm_pkg::tsbm_status_t        status,
    output tsbm_pkg::tsbm_cmd_t           cmd
);
    import tsbm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_LOAD:  cmd.load  = status.load_ok;
                        MODE_CLEAR: cmd.clear = 1'b1;
                        MODE_QUERY: begin
                            if (status.query_ok) begin
                                cmd.start  = 1'b1;
                                state_next = status.refs_empty ? ST_DRAIN : ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tsbm_datapath.sv =====
// ----------------------------------------------------------------------------
// tsbm_datapath
// Reference store, registers, pair-distance pipeline and winner tracking.
// ----------------------------------------------------------------------------
module tsbm_datapath #(
    parameter int MAX_REFS = tsbm_pkg::MAX_REFS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [tsbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tsbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_z,
    input  logic signed [tsbm_pkg::SLOPE_W-1:0]   s_slope_x,
    input  logic signed [tsbm_pkg::SLOPE_W-1:0]   s_slope_y,
    input  logic [tsbm_pkg::ID_W-1:0]             s_track_id,
    input  logic [tsbm_pkg::PLATE_W-1:0]          s_first_plate,
    input  logic [tsbm_pkg::PLATE_W-1:0]          s_last_plate,
    input  logic [tsbm_pkg::SEG_W-1:0]            s_seg_count,
    input  tsbm_pkg::tsbm_cmd_t                   cmd,
    output tsbm_pkg::tsbm_status_t                status,
    output logic [tsbm_pkg::DIST_W-1:0]           m_best_score,
    output logic [tsbm_pkg::DIST_W-1:0]           m_forward_b,
    output logic [tsbm_pkg::DIST_W-1:0]           m_backward_b,
    output logic [tsbm_pkg::ID_W-1:0]             m_best_id,
    output logic [tsbm_pkg::PLATE_W-1:0]          m_best_first_plate,
    output logic [tsbm_pkg::PLATE_W-1:0]          m_plate_gap,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_proj_dx,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_proj_dy,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_mid_dx,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_mid_dy,
    output logic                                  m_matched
);
    import tsbm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_REFS + 1);
    localparam int ADDR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int ENT_W  = $bits(ref_entry_t);
    localparam int DD_W   = POS_W + 2;     // reference minus offset query
    localparam int DZ_W   = POS_W + 1;
    localparam int QP_W   = POS_W + 1;     // offset query position
    localparam int SS_W   = SLOPE_W + 1;
    localparam int PF_W   = DZ_W + SLOPE_W;
    localparam int PM_W   = DZ_W + SS_W;
    localparam int ACC_W  = 42;
    localparam logic signed [ACC_W-1:0] RND14 = ACC_W'(64'sd8192);
    localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(64'sd16384);

    // ---------------- configuration registers
    logic [SEG_W-1:0]          min_seg_reg;
    logic [PLATE_W-1:0]        ref_lo_reg, ref_hi_reg, qry_lo_reg, qry_lim_reg;
    logic signed [POS_W-1:0]   off_x_reg, off_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_seg_reg <= RST_MIN_SEGMENTS;
            ref_lo_reg  <= RST_REF_PLATE_LOW;
            ref_hi_reg  <= RST_REF_PLATE_HIGH;
            qry_lo_reg  <= RST_QRY_PLATE_LOW;
            qry_lim_reg <= RST_QRY_PLATE_LIM;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_SEGMENTS:   min_seg_reg <= cfg_data[SEG_W-1:0];
                CFG_REF_PLATE_LOW:  ref_lo_reg  <= cfg_data[PLATE_W-1:0];
                CFG_REF_PLATE_HIGH: ref_hi_reg  <= cfg_data[PLATE_W-1:0];
                CFG_QRY_PLATE_LOW:  qry_lo_reg  <= cfg_data[PLATE_W-1:0];
                CFG_QRY_PLATE_LIM:  qry_lim_reg <= cfg_data[PLATE_W-1:0];
                CFG_QRY_OFFSET_X:   off_x_reg   <= cfg_data[POS_W-1:0];
                CFG_QRY_OFFSET_Y:   off_y_reg   <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- store fill count and scan address
    logic [CNT_W-1:0] count_reg, addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            addr_reg  <= '0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.load) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.start) begin
                addr_reg <= '0;
            end else if (cmd.issue) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
        end
    end

    assign status.load_ok = (s_seg_count >= min_seg_reg) && (s_last_plate >= ref_lo_reg)
                            && (s_last_plate <= ref_hi_reg)
                            && (count_reg < CNT_W'(MAX_REFS));
    assign status.query_ok = (s_seg_count >= min_seg_reg) && (s_first_plate >= qry_lo_reg)
                             && (s_first_plate < qry_lim_reg);
    assign status.refs_empty = (count_reg == '0);
    assign status.issue_last = (addr_reg + CNT_W'(1) == count_reg);

    // ---------------- reference memory
    logic [ENT_W-1:0] mem [MAX_REFS];
    ref_entry_t       wr_ent, rd_reg;

    assign wr_ent = '{x: s_pos_x, y: s_pos_y, z: s_pos_z, sx: s_slope_x, sy: s_slope_y,
                      id: s_track_id, fp: s_first_plate, lp: s_last_plate};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[count_reg[ADDR_W-1:0]] <= wr_ent;
        end
        if (cmd.issue) begin
            rd_reg <= mem[addr_reg[ADDR_W-1:0]];
        end
    end

    // ---------------- query latch
    logic signed [QP_W-1:0]    qx_reg, qy_reg;
    logic signed [POS_W-1:0]   qz_reg;
    logic signed [SLOPE_W-1:0] qtx_reg, qty_reg;
    logic [PLATE_W-1:0]        qfp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qx_reg  <= QP_W'(s_pos_x) + QP_W'(off_x_reg);
            qy_reg  <= QP_W'(s_pos_y) + QP_W'(off_y_reg);
            qz_reg  <= s_pos_z;
            qtx_reg <= s_slope_x;
            qty_reg <= s_slope_y;
            qfp_reg <= s_first_plate;
        end
    end

    // ---------------- stage valids
    logic                v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [ROOT_W-1:0]   vq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg} <= '0;
            vq_reg <= '0;
        end else begin
            v0_reg <= cmd.issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vq_reg <= {vq_reg[ROOT_W-2:0], v5_reg};
        end
    end

    assign status.pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | (|vq_reg);

    // ---------------- stage 1: differences
    logic signed [DD_W-1:0]    ddx1_reg, ddy1_reg;
    logic signed [DZ_W-1:0]    dz1_reg, adz1_reg;
    logic signed [SLOPE_W-1:0] rsx1_reg, rsy1_reg;
    logic signed [SS_W-1:0]    ssx1_reg, ssy1_reg;
    logic [ID_W-1:0]           id1_reg;
    logic [PLATE_W-1:0]        fp1_reg, gap1_reg;
    logic signed [DZ_W-1:0]    dz_c;

    assign dz_c = DZ_W'(rd_reg.z) - DZ_W'(qz_reg);

    always_ff @(posedge aclk) begin
        ddx1_reg <= DD_W'(rd_reg.x) - DD_W'(qx_reg);
        ddy1_reg <= DD_W'(rd_reg.y) - DD_W'(qy_reg);
        dz1_reg  <= dz_c;
        adz1_reg <= dz_c[DZ_W-1] ? -dz_c : dz_c;
        rsx1_reg <= rd_reg.sx;
        rsy1_reg <= rd_reg.sy;
        ssx1_reg <= SS_W'(rd_reg.sx) + SS_W'(qtx_reg);
        ssy1_reg <= SS_W'(rd_reg.sy) + SS_W'(qty_reg);
        id1_reg  <= rd_reg.id;
        fp1_reg  <= rd_reg.fp;
        gap1_reg <= (qfp_reg > rd_reg.lp) ? qfp_reg - rd_reg.lp : rd_reg.lp - qfp_reg;
    end

    // ---------------- stage 2: slope products
    logic signed [PF_W-1:0] pfx2_reg, pfy2_reg, pbx2_reg, pby2_reg;
    logic signed [PM_W-1:0] pmx2_reg, pmy2_reg;
    logic signed [DD_W-1:0] ddx2_reg, ddy2_reg;
    logic [ID_W-1:0]        id2_reg;
    logic [PLATE_W-1:0]     fp2_reg, gap2_reg;

    always_ff @(posedge aclk) begin
        pfx2_reg <= dz1_reg * rsx1_reg;
        pfy2_reg <= dz1_reg * rsy1_reg;
        pbx2_reg <= dz1_reg * qtx_reg;
        pby2_reg <= dz1_reg * qty_reg;
        pmx2_reg <= adz1_reg * ssx1_reg;
        pmy2_reg <= adz1_reg * ssy1_reg;
        ddx2_reg <= ddx1_reg;
        ddy2_reg <= ddy1_reg;
        id2_reg  <= id1_reg;
        fp2_reg  <= fp1_reg;
        gap2_reg <= gap1_reg;
    end

    // ---------------- stage 3: offsets rounded to Q3
    logic signed [ACC_W-1:0] ax14, ay14, ax15, ay15;
    logic signed [ACC_W-1:0] fx_a, fy_a, bx_a, by_a, mx_a, my_a;
    side_t                   side3_reg;
    logic signed [OFF_W-1:0] bx3_reg, by3_reg;

    always_comb begin
        ax14 = ACC_W'(ddx2_reg) <<< 14;
        ay14 = ACC_W'(ddy2_reg) <<< 14;
        ax15 = ACC_W'(ddx2_reg) <<< 15;
        ay15 = ACC_W'(ddy2_reg) <<< 15;
        fx_a = (ax14 - ACC_W'(pfx2_reg) + RND14) >>> 14;
        fy_a = (ay14 - ACC_W'(pfy2_reg) + RND14) >>> 14;
        bx_a = (ACC_W'(pbx2_reg) - ax14 + RND14) >>> 14;
        by_a = (ACC_W'(pby2_reg) - ay14 + RND14) >>> 14;
        mx_a = (ax15 + ACC_W'(pmx2_reg) + RND15) >>> 15;
        my_a = (ay15 + ACC_W'(pmy2_reg) + RND15) >>> 15;
    end

    always_ff @(posedge aclk) begin
        side3_reg <= '{fx: fx_a[OFF_W-1:0], fy: fy_a[OFF_W-1:0],
                       mx: mx_a[OFF_W-1:0], my: my_a[OFF_W-1:0],
                       id: id2_reg, fp: fp2_reg, gap: gap2_reg};
        bx3_reg <= bx_a[OFF_W-1:0];
        by3_reg <= by_a[OFF_W-1:0];
    end

    // ---------------- stage 4: squares
    logic signed [NORM_W-1:0] sq_fx, sq_fy, sq_bx, sq_by;
    logic [NORM_W-1:0]        sfx4_reg, sfy4_reg, sbx4_reg, sby4_reg;
    side_t                    side4_reg;

    assign sq_fx = side3_reg.fx * side3_reg.fx;
    assign sq_fy = side3_reg.fy * side3_reg.fy;
    assign sq_bx = bx3_reg * bx3_reg;
    assign sq_by = by3_reg * by3_reg;

    always_ff @(posedge aclk) begin
        sfx4_reg  <= $unsigned(sq_fx);
        sfy4_reg  <= $unsigned(sq_fy);
        sbx4_reg  <= $unsigned(sq_bx);
        sby4_reg  <= $unsigned(sq_by);
        side4_reg <= side3_reg;
    end

    // ---------------- stage 5: squared distances
    logic [NORM_W-1:0] nf5_reg, nb5_reg;
    side_t             side5_reg;

    always_ff @(posedge aclk) begin
        nf5_reg   <= sfx4_reg + sfy4_reg;
        nb5_reg   <= sbx4_reg + sby4_reg;
        side5_reg <= side4_reg;
    end

    // ---------------- square roots, side data delayed to match
    logic [ROOT_W-1:0] root_f, root_b;
    side_t             sideq_reg [ROOT_W];

    tsbm_isqrt #(.NORM_W(NORM_W), .ROOT_W(ROOT_W)) u_sqrt_fwd (
        .aclk     (aclk),
        .radicand (nf5_reg),
        .root     (root_f)
    );

    tsbm_isqrt #(.NORM_W(NORM_W), .ROOT_W(ROOT_W)) u_sqrt_bwd (
        .aclk     (aclk),
        .radicand (nb5_reg),
        .root     (root_b)
    );

    always_ff @(posedge aclk) begin
        sideq_reg[0] <= side5_reg;
        for (int i = 1; i < ROOT_W; i++) begin
            sideq_reg[i] <= sideq_reg[i-1];
        end
    end

    // ---------------- winner tracking
    logic [ROOT_W:0]   score_sum;
    logic [ROOT_W-1:0] score;
    logic [ROOT_W-1:0] best_reg, bf_reg, bb_reg;
    side_t             win_reg;
    logic              found_reg;
    side_t             last_side;

    assign last_side = sideq_reg[ROOT_W-1];
    assign score_sum = (ROOT_W + 1)'(root_f) + (ROOT_W + 1)'(root_b);
    assign score     = score_sum[ROOT_W:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.start) begin
            found_reg <= 1'b0;
        end else if (vq_reg[ROOT_W-1] && score < best_reg) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            best_reg <= SCORE_LIMIT;
            bf_reg   <= '0;
            bb_reg   <= '0;
            win_reg  <= '0;
        end else if (vq_reg[ROOT_W-1] && score < best_reg) begin
            best_reg <= score;
            bf_reg   <= root_f;
            bb_reg   <= root_b;
            win_reg  <= last_side;
        end
    end

    assign m_best_score       = sat_dist(best_reg);
    assign m_forward_b        = sat_dist(bf_reg);
    assign m_backward_b       = sat_dist(bb_reg);
    assign m_best_id          = win_reg.id;
    assign m_best_first_plate = win_reg.fp;
    assign m_plate_gap        = win_reg.gap;
    assign m_proj_dx          = sat_off(win_reg.fx);
    assign m_proj_dy          = sat_off(win_reg.fy);
    assign m_mid_dx           = sat_off(win_reg.mx);
    assign m_mid_dy           = sat_off(win_reg.my);
    assign m_matched          = found_reg;

endmodule

// ===== rtl/core/track_segment_best_match.sv =====
// ----------------------------------------------------------------------------
// track_segment_best_match
// Reference track store with best-match search for query tracks.
// ----------------------------------------------------------------------------
// Load requests (mode 0) that pass the segment-count and last-plate cuts are
// written to the reference store until it holds MAX_REFS entries; later
// loads are dropped. A clear request (mode 2) empties the store. A query
// request (mode 1) that passes its cuts is shifted by the manual offset and
// compared with every stored reference, one reference per cycle through a
// pipelined datapath (memory read, slope products, rounding, squares, two
// 27-stage square roots, winner compare). The single read port of the
// reference memory and the pipeline depth set how long a query takes; the
// block takes no new request until the result has been taken on the m_
// channel. Queries that fail their cuts, and mode 3, give no result. The
// store needs no clearing pass after reset: only entries below the fill
// count are ever read. Configuration writes are accepted on every cycle.
// ----------------------------------------------------------------------------
module track_segment_best_match #(
    parameter int MAX_REFS = tsbm_pkg::MAX_REFS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tsbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tsbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tsbm_pkg::MODE_W-1:0]           s_mode,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [tsbm_pkg::POS_W-1:0]     s_pos_z,
    input  logic signed [tsbm_pkg::SLOPE_W-1:0]   s_slope_x,
    input  logic signed [tsbm_pkg::SLOPE_W-1:0]   s_slope_y,
    input  logic [tsbm_pkg::ID_W-1:0]             s_track_id,
    input  logic [tsbm_pkg::PLATE_W-1:0]          s_first_plate,
    input  logic [tsbm_pkg::PLATE_W-1:0]          s_last_plate,
    input  logic [tsbm_pkg::SEG_W-1:0]            s_seg_count,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tsbm_pkg::DIST_W-1:0]           m_best_score,
    output logic [tsbm_pkg::DIST_W-1:0]           m_forward_b,
    output logic [tsbm_pkg::DIST_W-1:0]           m_backward_b,
    output logic [tsbm_pkg::ID_W-1:0]             m_best_id,
    output logic [tsbm_pkg::PLATE_W-1:0]          m_best_first_plate,
    output logic [tsbm_pkg::PLATE_W-1:0]          m_plate_gap,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_proj_dx,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_proj_dy,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_mid_dx,
    output logic signed [tsbm_pkg::OUT_W-1:0]     m_mid_dy,
    output logic                                  m_matched
);
    import tsbm_pkg::*;

    tsbm_cmd_t    cmd;
    tsbm_status_t status;

    // Registers are plain flops: always take a write.
    assign cfg_ready = 1'b1;

    // Sequence requests and the reference scan.
    tsbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the store, registers and distance pipeline; the winner registers
    // drive the result ports directly and stay put until the result is taken.
    tsbm_datapath #(.MAX_REFS(MAX_REFS)) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_pos_x            (s_pos_x),
        .s_pos_y            (s_pos_y),
        .s_pos_z            (s_pos_z),
        .s_slope_x          (s_slope_x),
        .s_slope_y          (s_slope_y),
        .s_track_id         (s_track_id),
        .s_first_plate      (s_first_plate),
        .s_last_plate       (s_last_plate),
        .s_seg_count        (s_seg_count),
        .cmd                (cmd),
        .status             (status),
        .m_best_score       (m_best_score),
        .m_forward_b        (m_forward_b),
        .m_backward_b       (m_backward_b),
        .m_best_id          (m_best_id),
        .m_best_first_plate (m_best_first_plate),
        .m_plate_gap        (m_plate_gap),
        .m_proj_dx          (m_proj_dx),
        .m_proj_dy          (m_proj_dy),
        .m_mid_dx           (m_mid_dx),
        .m_mid_dy           (m_mid_dy),
        .m_matched          (m_matched)
    );

endmodule

// ===== tb/track_segment_best_match_test.sv =====
// ----------------------------------------------------------------------------
// track_segment_best_match_test
// Self-checking bench for the track segment best-match block. A local
// predictor keeps its own reference store and register copy, works out the
// winner of every accepted query and checks each result field by field.
// Directed cases cover cuts, ties, full store and clear; random phases run
// clustered tracks with noise under several register settings and idling.
// ----------------------------------------------------------------------------
module track_segment_best_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsbm_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;
    localparam longint NO_MATCH_SCORE = 80000;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
        logic signed [SLOPE_W-1:0] sx;
        logic signed [SLOPE_W-1:0] sy;
        logic [ID_W-1:0]           id;
        logic [PLATE_W-1:0]        fp;
        logic [PLATE_W-1:0]        lp;
        logic [SEG_W-1:0]          ns;
    } track_req_t;

    typedef struct packed {
        logic [DIST_W-1:0]  score;
        logic [DIST_W-1:0]  fwd;
        logic [DIST_W-1:0]  bwd;
        logic [ID_W-1:0]    id;
        logic [PLATE_W-1:0] bfp;
        logic [PLATE_W-1:0] gap;
        logic [OUT_W-1:0]   pdx;
        logic [OUT_W-1:0]   pdy;
        logic [OUT_W-1:0]   mdx;
        logic [OUT_W-1:0]   mdy;
        logic               matched;
    } match_res_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [MODE_W-1:0] s_mode;
    logic signed [POS_W-1:0] s_pos_x;
    logic signed [POS_W-1:0] s_pos_y;
    logic signed [POS_W-1:0] s_pos_z;
    logic signed [SLOPE_W-1:0] s_slope_x;
    logic signed [SLOPE_W-1:0] s_slope_y;
    logic [ID_W-1:0] s_track_id;
    logic [PLATE_W-1:0] s_first_plate;
    logic [PLATE_W-1:0] s_last_plate;
    logic [SEG_W-1:0] s_seg_count;
    logic m_valid;
    logic m_ready;
    logic [DIST_W-1:0] m_best_score;
    logic [DIST_W-1:0] m_forward_b;
    logic [DIST_W-1:0] m_backward_b;
    logic [ID_W-1:0] m_best_id;
    logic [PLATE_W-1:0] m_best_first_plate;
    logic [PLATE_W-1:0] m_plate_gap;
    logic signed [OUT_W-1:0] m_proj_dx;
    logic signed [OUT_W-1:0] m_proj_dy;
    logic signed [OUT_W-1:0] m_mid_dx;
    logic signed [OUT_W-1:0] m_mid_dy;
    logic m_matched;

    track_segment_best_match u_dut (.*);

    // Register copy held by the predictor
    logic [SEG_W-1:0]   cut_min_seg;
    logic [PLATE_W-1:0] cut_ref_lo;
    logic [PLATE_W-1:0] cut_ref_hi;
    logic [PLATE_W-1:0] cut_qry_lo;
    logic [PLATE_W-1:0] cut_qry_lim;
    logic signed [POS_W-1:0] shift_x;
    logic signed [POS_W-1:0] shift_y;

    // Reference store copy
    longint ref_px [STORE_DEPTH];
    longint ref_py [STORE_DEPTH];
    longint ref_pz [STORE_DEPTH];
    longint ref_tx [STORE_DEPTH];
    longint ref_ty [STORE_DEPTH];
    logic [ID_W-1:0]    ref_tid [STORE_DEPTH];
    logic [PLATE_W-1:0] ref_fpl [STORE_DEPTH];
    logic [PLATE_W-1:0] ref_lpl [STORE_DEPTH];
    int stored_refs;

    match_res_t pending_matches[$];
    match_res_t oldest_match;
    int error_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    longint center_x;
    longint center_y;
    int next_id;

    // Clock: 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Arithmetic helpers of the predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned sqrt_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Round to nearest, ties toward plus infinity (>>> floors)
    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned norm_of(longint dx, longint dy);
        longint unsigned ax;
        longint unsigned ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return sqrt_floor(ax * ax + ay * ay);
    endfunction

    function automatic logic [DIST_W-1:0] clip_dist(longint unsigned v);
        return (v > 1048575) ? {DIST_W{1'b1}} : v[DIST_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] clip_off(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Predictor: advance the store copy and queue the expected winner
    // ------------------------------------------------------------------
    task automatic predict_request(track_req_t r);
        match_res_t want;
        longint qx, qy, qz, ddx, ddy, dz, adz, fx, fy, bx, by;
        longint best, bf, bb, sc;
        want = '0;
        best = NO_MATCH_SCORE;
        if (r.mode == MODE_CLEAR) begin
            stored_refs = 0;
        end else if (r.mode == MODE_LOAD) begin
            if (r.ns >= cut_min_seg && r.lp >= cut_ref_lo && r.lp <= cut_ref_hi
                    && stored_refs < STORE_DEPTH) begin
                ref_px[stored_refs] = r.x;
                ref_py[stored_refs] = r.y;
                ref_pz[stored_refs] = r.z;
                ref_tx[stored_refs] = r.sx;
                ref_ty[stored_refs] = r.sy;
                ref_tid[stored_refs] = r.id;
                ref_fpl[stored_refs] = r.fp;
                ref_lpl[stored_refs] = r.lp;
                stored_refs++;
            end
        end else if (r.mode == MODE_QUERY && r.ns >= cut_min_seg
                && r.fp >= cut_qry_lo && r.fp < cut_qry_lim) begin
            qx = longint'(r.x) + longint'(shift_x);
            qy = longint'(r.y) + longint'(shift_y);
            qz = r.z;
            for (int j = 0; j < stored_refs; j++) begin
                ddx = ref_px[j] - qx;
                ddy = ref_py[j] - qy;
                dz = ref_pz[j] - qz;
                adz = (dz < 0) ? -dz : dz;
                fx = round_q(ddx * 16384 - dz * ref_tx[j], 14);
                fy = round_q(ddy * 16384 - dz * ref_ty[j], 14);
                bx = round_q(-ddx * 16384 + dz * longint'(r.sx), 14);
                by = round_q(-ddy * 16384 + dz * longint'(r.sy), 14);
                bf = norm_of(fx, fy);
                bb = norm_of(bx, by);
                sc = (bf + bb) >> 1;
                // strict compare keeps the earliest reference on a tie
                if (sc < best) begin
                    best = sc;
                    want.matched = 1'b1;
                    want.fwd = clip_dist(bf);
                    want.bwd = clip_dist(bb);
                    want.id = ref_tid[j];
                    want.bfp = ref_fpl[j];
                    want.gap = (r.fp > ref_lpl[j]) ? r.fp - ref_lpl[j] : ref_lpl[j] - r.fp;
                    want.pdx = clip_off(fx);
                    want.pdy = clip_off(fy);
                    want.mdx = clip_off(round_q(ddx * 32768 + adz * (ref_tx[j] + r.sx), 15));
                    want.mdy = clip_off(round_q(ddy * 32768 + adz * (ref_ty[j] + r.sy), 15));
                end
            end
            want.score = clip_dist(best);
            pending_matches = {pending_matches, want};
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic send_request(track_req_t r);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_pos_x       <= r.x;
        s_pos_y       <= r.y;
        s_pos_z       <= r.z;
        s_slope_x     <= r.sx;
        s_slope_y     <= r.sy;
        s_track_id    <= r.id;
        s_first_plate <= r.fp;
        s_last_plate  <= r.lp;
        s_seg_count   <= r.ns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(r);
    endtask

    // Hold off requests until every expected result is back, then settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all seven registers back to back while the block is idle
    task automatic set_registers(int min_seg, int ref_lo, int ref_hi, int q_lo, int q_lim,
                                 int off_x, int off_y);
        int vals [7];
        vals = '{min_seg, ref_lo, ref_hi, q_lo, q_lim, off_x, off_y};
        drain_results();
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (CFG_IDX_W'(i))
                CFG_MIN_SEGMENTS:   cut_min_seg = SEG_W'(vals[i]);
                CFG_REF_PLATE_LOW:  cut_ref_lo  = PLATE_W'(vals[i]);
                CFG_REF_PLATE_HIGH: cut_ref_hi  = PLATE_W'(vals[i]);
                CFG_QRY_PLATE_LOW:  cut_qry_lo  = PLATE_W'(vals[i]);
                CFG_QRY_PLATE_LIM:  cut_qry_lim = PLATE_W'(vals[i]);
                CFG_QRY_OFFSET_X:   shift_x     = POS_W'(vals[i]);
                CFG_QRY_OFFSET_Y:   shift_y     = POS_W'(vals[i]);
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic int spread(int half);
        return int'($urandom_range(2 * half)) - half;
    endfunction

    function automatic track_req_t noise_request();
        track_req_t r;
        r.mode = MODE_W'($urandom_range(3));
        r.x    = POS_W'($urandom);
        r.y    = POS_W'($urandom);
        r.z    = POS_W'($urandom);
        r.sx   = SLOPE_W'($urandom);
        r.sy   = SLOPE_W'($urandom);
        r.id   = ID_W'($urandom);
        r.fp   = PLATE_W'($urandom);
        r.lp   = PLATE_W'($urandom);
        r.ns   = SEG_W'($urandom);
        return r;
    endfunction

    // Track near the phase center that passes the cuts where the window allows
    function automatic track_req_t near_request(logic [MODE_W-1:0] mode);
        track_req_t r;
        r.mode = mode;
        r.x  = POS_W'(center_x + spread(4000));
        r.y  = POS_W'(center_y + spread(4000));
        r.z  = POS_W'(spread(30000));
        r.sx = SLOPE_W'(spread(2500));
        r.sy = SLOPE_W'(spread(2500));
        r.id = ID_W'($urandom);
        r.fp = PLATE_W'($urandom);
        r.lp = PLATE_W'($urandom);
        r.ns = SEG_W'($urandom_range(63, cut_min_seg));
        if (mode == MODE_LOAD && cut_ref_lo <= cut_ref_hi)
            r.lp = PLATE_W'($urandom_range(cut_ref_hi, cut_ref_lo));
        if (mode == MODE_QUERY && cut_qry_lo < cut_qry_lim)
            r.fp = PLATE_W'($urandom_range(cut_qry_lim - 1, cut_qry_lo));
        return r;
    endfunction

    function automatic track_req_t plain_request(logic [MODE_W-1:0] mode, int x, int z,
                                                 int sx, int fp, int lp, int ns);
        track_req_t r;
        r = '0;
        r.mode = mode;
        r.x = POS_W'(x);
        r.y = POS_W'(x / 2);
        r.z = POS_W'(z);
        r.sx = SLOPE_W'(sx);
        r.sy = SLOPE_W'(-sx);
        r.id = ID_W'(next_id);
        r.fp = PLATE_W'(fp);
        r.lp = PLATE_W'(lp);
        r.ns = SEG_W'(ns);
        next_id++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("unexpected result, best_id", m_best_id, 0);
            end else begin
                oldest_match = pending_matches.pop_front();
                check_field("best_score", {m_best_score}, oldest_match.score);
                check_field("forward_b", {m_forward_b}, oldest_match.fwd);
                check_field("backward_b", {m_backward_b}, oldest_match.bwd);
                check_field("best_id", {m_best_id}, oldest_match.id);
                check_field("best_first_plate", {m_best_first_plate}, oldest_match.bfp);
                check_field("plate_gap", {m_plate_gap}, oldest_match.gap);
                check_field("proj_dx", {m_proj_dx}, oldest_match.pdx);
                check_field("proj_dy", {m_proj_dy}, oldest_match.pdy);
                check_field("mid_dx", {m_mid_dx}, oldest_match.mdx);
                check_field("mid_dy", {m_mid_dy}, oldest_match.mdy);
                check_field("matched", {m_matched}, oldest_match.matched);
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if nothing is accepted for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("track_segment_best_match_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset cuts: accepted and rejected loads, a tie, query window edges,
    // ignored mode, clear, empty store and extreme field values.
    task automatic test_reset_cuts();
        track_req_t r;
        send_request(plain_request(MODE_LOAD, 1000, 8000, 300, 10, 26, 3));
        send_request(plain_request(MODE_LOAD, 1000, 8000, 300, 11, 26, 3));  // tie
        send_request(plain_request(MODE_LOAD, 1200, 8000, 300, 12, 27, 2));  // too few segs
        send_request(plain_request(MODE_LOAD, 1200, 8000, 300, 12, 32, 9));  // plate high
        send_request(plain_request(MODE_LOAD, 1200, 8000, 300, 12, 25, 9));  // plate low
        send_request(plain_request(MODE_LOAD, 900, -6000, -200, 13, 31, 63));
        send_request(plain_request(MODE_QUERY, 1100, -2000, 250, 31, 0, 3));
        send_request(plain_request(MODE_QUERY, 950, 0, -100, 39, 0, 63));
        send_request(plain_request(MODE_QUERY, 1100, 0, 250, 40, 0, 9));     // plate limit
        send_request(plain_request(MODE_QUERY, 1100, 0, 250, 30, 0, 9));     // plate low
        send_request(plain_request(MODE_QUERY, 1100, 0, 250, 35, 0, 2));     // too few segs
        send_request(plain_request(MODE_QUERY, 4194303, 4194303, 32767, 35, 0, 9));
        send_request(plain_request(MODE_QUERY, -4194304, -4194304, -32768, 35, 0, 9));
        r = plain_request(MODE_QUERY, 1000, 8000, 300, 33, 0, 9);
        r.mode = 2'd3;  // ignored mode
        send_request(r);
        send_request(plain_request(MODE_LOAD, 4194303, 4194303, 32767, 0, 28, 9));
        send_request(plain_request(MODE_QUERY, 4194303, 4194303, 32767, 33, 0, 9));
        send_request(plain_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
        send_request(plain_request(MODE_QUERY, 1000, 8000, 300, 33, 0, 9));  // empty store
    endtask

    // Fill the store past its depth, then query it full
    task automatic test_store_full();
        track_req_t r;
        send_request(plain_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < STORE_DEPTH + 6; i++) begin
            r = near_request(MODE_LOAD);
            // a close pair beyond the depth must be dropped
            if (i >= STORE_DEPTH) begin
                r.x = POS_W'(center_x);
                r.y = POS_W'(center_y);
                r.z = '0;
                r.sx = '0;
                r.sy = '0;
            end
            send_request(r);
        end
        r = near_request(MODE_QUERY);
        r.x = POS_W'(center_x);
        r.y = POS_W'(center_y);
        r.z = '0;
        send_request(r);
        send_request(near_request(MODE_QUERY));
        send_request(plain_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    endtask

    // Register extremes: strictest and loosest cuts, offset range ends
    task automatic test_register_extremes();
        set_registers(63, 127, 127, 127, 127, 4194303, -4194304);
        for (int i = 0; i < 12; i++) send_request(i % 3 == 2 ? noise_request()
                                                  : near_request(MODE_LOAD));
        for (int i = 0; i < 4; i++) send_request(near_request(MODE_QUERY));
        set_registers(0, 0, 127, 0, 127, -4194304, 4194303);
        for (int i = 0; i < 8; i++) send_request(near_request(MODE_LOAD));
        for (int i = 0; i < 6; i++) send_request(near_request(MODE_QUERY));
        set_registers(0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++) send_request(noise_request());
        send_request(plain_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    endtask

    // Random phase: clustered tracks with noise, clears keep the store small
    task automatic test_random_phase(int count, int idle, int stall);
        int pick;
        idle_pct = idle;
        stall_pct = stall;
        center_x = spread(4000000);
        center_y = spread(4000000);
        set_registers($urandom_range(5), $urandom_range(40), $urandom_range(127, 30),
                      $urandom_range(20), $urandom_range(127, 50), spread(3000),
                      spread(3000));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (stored_refs > 40 || pick < 4) begin
                send_request(plain_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
            end else if (pick < 14) begin
                send_request(noise_request());
            end else if (pick < 50) begin
                send_request(near_request(MODE_LOAD));
            end else begin
                send_request(near_request(MODE_QUERY));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_mode = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_slope_x = '0;
        s_slope_y = '0;
        s_track_id = '0;
        s_first_plate = '0;
        s_last_plate = '0;
        s_seg_count = '0;
        m_ready = 1'b0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        next_id = 1;
        center_x = 12000;
        center_y = -7000;
        // predictor copy of the reset state
        cut_min_seg = RST_MIN_SEGMENTS;
        cut_ref_lo = RST_REF_PLATE_LOW;
        cut_ref_hi = RST_REF_PLATE_HIGH;
        cut_qry_lo = RST_QRY_PLATE_LOW;
        cut_qry_lim = RST_QRY_PLATE_LIM;
        shift_x = '0;
        shift_y = '0;
        stored_refs = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_cuts();
        test_store_full();
        test_register_extremes();
        test_random_phase(150, 0, 0);
        test_random_phase(140, 58, 0);
        test_random_phase(140, 0, 58);
        test_random_phase(150, 7, 7);

        drain_results();
        if (error_count == 0) begin
            $display("track_segment_best_match_test passed");
        end else begin
            $display("track_segment_best_match_test failed");
        end
        $finish;
    end

endmodule
